/* rtl/rpfl_pkg.sv */
`timescale 1ns / 1ps
// Package for the reference-counted page free list.
// Field widths, codes and the controller/datapath command structs; no dependencies.
package rpfl_pkg;

  localparam int REG_W      = 15;
  localparam int KIND_W     = 3;
  localparam int PAGE_W     = 14;
  localparam int STATUS_W   = 2;
  localparam int COUNT_O_W  = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [REG_W-1:0] PAGE_COUNT_RST    = 15'd16384;
  localparam logic [REG_W-1:0] IO_HOLE_FIRST_RST = 15'd160;
  localparam logic [REG_W-1:0] IO_HOLE_END_RST   = 15'd256;
  localparam logic [REG_W-1:0] KERNEL_END_RST    = 15'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_COUNT    = 3'd0,
    REG_IO_HOLE_FIRST = 3'd1,
    REG_IO_HOLE_END   = 3'd2,
    REG_KERNEL_END    = 3'd3
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_INCREF = 3'd2,
    KIND_DECREF = 3'd3,
    KIND_FREE   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_COUNT = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic init_start;
    logic init_step;
    logic init_fin;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic init_req;
    logic init_done;
  } sts_t;

endpackage

/* rtl/rpfl_req_if.sv */
`timescale 1ns / 1ps
// Request channel: operation kind and page number with valid/ready.
// Depends on rpfl_pkg for field widths.
interface rpfl_req_if import rpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, kind, page_number, input ready);
  modport sink   (input valid, kind, page_number, output ready);
endinterface

/* rtl/rpfl_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: granted page, status, freed flag and count with valid/ready.
// Depends on rpfl_pkg for field widths.
interface rpfl_rsp_if import rpfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_W-1:0]    granted_page;
  logic [STATUS_W-1:0]  status;
  logic                 page_freed;
  logic [COUNT_O_W-1:0] count_after;

  modport source (output valid, granted_page, status, page_freed, count_after,
                  input ready);
  modport sink   (input valid, granted_page, status, page_freed, count_after,
                  output ready);
endinterface

/* rtl/refcounted_page_free_list.sv */
`timescale 1ns / 1ps
// Reference-counted physical page allocator with a LIFO free list. Alloc, incref,
// decref and free each read the link and count RAMs at the page (or list head)
// on accept, then update and write back in the exec state. Init walks the managed
// pages one per cycle through the RAM write ports (page_count clamped to
// MAX_PAGES). A finished result sits in an output register, so the next beat is
// taken while it waits. The RAMs are not cleared at reset: issue init before any
// other operation. Depends on rpfl_pkg, the channel interfaces, rpfl_ctrl and
// rpfl_datapath.
module refcounted_page_free_list import rpfl_pkg::*; #(
  parameter int MAX_PAGES   = 16384,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  rpfl_req_if.sink             req_i,
  rpfl_rsp_if.source           rsp_o
);
  ctl_t ctl;
  sts_t sts;

  rpfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rpfl_datapath #(.MAX_PAGES(MAX_PAGES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_kind_i      (req_i.kind),
    .in_page_i      (req_i.page_number),
    .granted_page_o (rsp_o.granted_page),
    .status_o       (rsp_o.status),
    .page_freed_o   (rsp_o.page_freed),
    .count_after_o  (rsp_o.count_after)
  );
endmodule

/* rtl/rpfl_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/rpfl_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, list head, init walk counter, link and
// count RAMs and the result register. Depends on rpfl_pkg and rpfl_ram.
module rpfl_datapath import rpfl_pkg::*; #(
  parameter int MAX_PAGES   = 16384,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic [KIND_W-1:0]    in_kind_i,
  input  logic [PAGE_W-1:0]    in_page_i,
  output logic [PAGE_W-1:0]    granted_page_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 page_freed_o,
  output logic [COUNT_O_W-1:0] count_after_o
);
  localparam int PW    = $clog2(MAX_PAGES);
  localparam int AW    = PW + 1;
  localparam int CMP_W = (AW > REG_W) ? AW : REG_W;
  localparam logic [AW-1:0]          MARKER    = AW'(MAX_PAGES);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [REG_W-1:0] page_count_q, hole_first_q, hole_end_q, kern_end_q;
  logic [AW-1:0]    head_q, head_d, idx_q, idx_d;
  logic [KIND_W-1:0] op_q;
  logic [PAGE_W-1:0] page_q;

  logic [PAGE_W-1:0]    granted_q, granted_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 freed_q, freed_d;
  logic [COUNT_O_W-1:0] cnt_out_q, cnt_out_d;

  logic [CMP_W-1:0] n_eff, pg_ext, in_pg_ext, idx_ext, head_ext;
  logic             idx_live, idx_rsv, head_empty;

  logic             cnt_we, link_we, rd_en;
  logic [PW-1:0]    cnt_waddr, link_waddr, raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rd, cnt_new;
  logic [AW-1:0]    link_wdata, link_rd;
  logic             ex_cnt_we, ex_push;
  logic [31:0]      cnt32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= PAGE_COUNT_RST;
      hole_first_q <= IO_HOLE_FIRST_RST;
      hole_end_q   <= IO_HOLE_END_RST;
      kern_end_q   <= KERNEL_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAGE_COUNT:    page_count_q <= cfg_data_i;
        REG_IO_HOLE_FIRST: hole_first_q <= cfg_data_i;
        REG_IO_HOLE_END:   hole_end_q   <= cfg_data_i;
        REG_KERNEL_END:    kern_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_eff = (CMP_W'(page_count_q) > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES)
                                                            : CMP_W'(page_count_q);
  assign pg_ext    = CMP_W'(page_q);
  assign in_pg_ext = CMP_W'(in_page_i);
  assign idx_ext   = CMP_W'(idx_q);
  assign head_ext  = CMP_W'(head_q);
  assign idx_live  = idx_ext < n_eff;
  assign idx_rsv   = (idx_ext == '0)
                  || (idx_ext >= CMP_W'(hole_first_q) && idx_ext < CMP_W'(hole_end_q))
                  || (idx_ext >= CMP_W'(hole_end_q) && idx_ext < CMP_W'(kern_end_q));
  assign head_empty = head_q >= MARKER;

  assign sts_o.init_req  = in_kind_i == KIND_INIT;
  assign sts_o.init_done = !idx_live;

  // read both stores at accept: the list head for alloc, the page otherwise
  assign rd_en = ctl_i.accept;
  assign raddr = (in_kind_i == KIND_ALLOC) ? head_q[PW-1:0] : in_pg_ext[PW-1:0];

  always_comb begin
    granted_d = '0;
    status_d  = ST_OK;
    freed_d   = 1'b0;
    cnt_new   = cnt_rd;
    ex_cnt_we = 1'b0;
    ex_push   = 1'b0;
    head_d    = head_q;
    cnt32     = '0;
    case (op_q)
      KIND_ALLOC: begin
        if (head_empty) begin
          status_d = ST_EMPTY;
        end else begin
          granted_d = head_ext[PAGE_W-1:0];
          cnt32     = 32'(cnt_rd);
          head_d    = link_rd;
        end
      end
      KIND_INCREF, KIND_DECREF, KIND_FREE: begin
        if (pg_ext >= n_eff) begin
          status_d = ST_RANGE;
        end else if (op_q == KIND_INCREF) begin
          if (cnt_rd != COUNT_MAX) begin
            cnt_new = cnt_rd + COUNT_WIDTH'(1);
          end
          ex_cnt_we = 1'b1;
          cnt32     = 32'(cnt_new);
        end else if (op_q == KIND_DECREF) begin
          if (cnt_rd == '0) begin
            status_d = ST_COUNT;
          end else begin
            cnt_new   = cnt_rd - COUNT_WIDTH'(1);
            ex_cnt_we = 1'b1;
            ex_push   = cnt_new == '0;
            cnt32     = 32'(cnt_new);
          end
        end else begin
          if (cnt_rd != '0) begin
            status_d = ST_COUNT;
            cnt32    = 32'(cnt_rd);
          end else begin
            ex_push = 1'b1;
          end
        end
        if (ex_push) begin
          freed_d = 1'b1;
          head_d  = pg_ext[AW-1:0];
        end
      end
      default: ;
    endcase
    cnt_out_d = cnt32[COUNT_O_W-1:0];
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.init_start) begin
      idx_d = '0;
    end else if (ctl_i.init_step && idx_live) begin
      idx_d = idx_q + AW'(1);
    end
  end

  assign cnt_we     = (ctl_i.exec && ex_cnt_we) || (ctl_i.init_step && idx_live);
  assign cnt_waddr  = ctl_i.exec ? pg_ext[PW-1:0] : idx_q[PW-1:0];
  assign cnt_wdata  = ctl_i.exec ? cnt_new : (idx_rsv ? COUNT_WIDTH'(1) : '0);
  assign link_we    = (ctl_i.exec && ex_push) || (ctl_i.init_step && idx_live && !idx_rsv);
  assign link_waddr = cnt_waddr;
  assign link_wdata = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= MARKER;
      idx_q  <= '0;
    end else begin
      idx_q <= idx_d;
      if (ctl_i.init_start) begin
        head_q <= MARKER;
      end else if (ctl_i.init_step && idx_live && !idx_rsv) begin
        head_q <= idx_q;
      end else if (ctl_i.exec) begin
        head_q <= head_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      op_q   <= in_kind_i;
      page_q <= in_page_i;
    end
    if (ctl_i.exec) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      freed_q   <= freed_d;
      cnt_out_q <= cnt_out_d;
    end else if (ctl_i.init_fin) begin
      granted_q <= '0;
      status_q  <= ST_OK;
      freed_q   <= 1'b0;
      cnt_out_q <= '0;
    end
  end

  rpfl_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_PAGES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (cnt_rd)
  );

  rpfl_ram #(.WIDTH(AW), .DEPTH(MAX_PAGES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (link_rd)
  );

  assign granted_page_o = granted_q;
  assign status_o       = status_q;
  assign page_freed_o   = freed_q;
  assign count_after_o  = cnt_out_q;
endmodule

/* rtl/rpfl_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences accept, read-modify-write, the init walk and the
// result register valid. Depends on rpfl_pkg.
module rpfl_ctrl import rpfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, out_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d             = state_q;
    ctl_o.accept        = 1'b0;
    ctl_o.init_start    = 1'b0;
    ctl_o.init_step     = 1'b0;
    ctl_o.init_fin      = 1'b0;
    ctl_o.exec          = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept     = 1'b1;
          ctl_o.init_start = sts_i.init_req;
          state_d          = sts_i.init_req ? S_INIT : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_INIT: begin
        if (!sts_i.init_done) begin
          ctl_o.init_step = 1'b1;
        end else if (out_free) begin
          ctl_o.init_fin = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load    = ctl_o.exec || ctl_o.init_fin;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.exec || ctl_o.init_fin |=> out_valid_q)
    else $error("finished item produced no result");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != S_IDLE)
    else $error("result appeared without an item in progress");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(ctl_o.exec || ctl_o.init_fin))
    else $error("pending result overwritten");
endmodule

/* tb/sv/refcounted_page_free_list_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_free_list: directed and random page
// operations, a reply predictor with its own link, count and head state, field checks.
// Depends on rpfl_pkg, rpfl_req_if, rpfl_rsp_if and the block itself.
module refcounted_page_free_list_test;
  import rpfl_pkg::*;

  localparam int PAGES = 16384;
  localparam logic [REG_W-1:0] NO_PAGE = 15'd16384;
  localparam logic [COUNT_O_W-1:0] COUNT_TOP = 16'hFFFF;
  localparam logic [KIND_W-1:0] KIND_NONE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NONE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NONE_HI = 3'd7;
  localparam int INCREF_OPS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 100;

  typedef struct {
    logic              is_cfg;
    reg_idx_e          idx;
    logic [REG_W-1:0]  data;
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
    logic              from_held;
  } stim_t;

  typedef struct {
    logic [PAGE_W-1:0]    granted;
    logic [STATUS_W-1:0]  status;
    logic                 freed;
    logic [COUNT_O_W-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic [KIND_W-1:0] req_kind = '0;
  logic [PAGE_W-1:0] req_page = '0;
  logic rsp_ready = 1'b0;

  rpfl_req_if req ();
  rpfl_rsp_if rsp ();

  assign req.valid       = req_valid;
  assign req.kind        = req_kind;
  assign req.page_number = req_page;
  assign rsp.ready       = rsp_ready;

  refcounted_page_free_list dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator state as the predictor sees it
  logic [REG_W-1:0]     link_mem  [PAGES];
  logic [COUNT_O_W-1:0] count_mem [PAGES];
  logic [REG_W-1:0]     list_head = NO_PAGE;
  logic [REG_W-1:0]     pages_cfg = PAGE_COUNT_RST;
  logic [REG_W-1:0]     hole_lo   = IO_HOLE_FIRST_RST;
  logic [REG_W-1:0]     hole_hi   = IO_HOLE_END_RST;
  logic [REG_W-1:0]     kern_end  = KERNEL_END_RST;
  logic [PAGE_W-1:0]    held_pages [$];

  stim_t  stim_q [$];
  reply_t pending_replies [$];
  int     sent_cnt = 0;
  int     done_cnt = 0;
  int     mismatches = 0;
  int     cycles = 0;

  function automatic int live_pages();
    return (pages_cfg > PAGES) ? PAGES : int'(pages_cfg);
  endfunction

  function automatic bit is_reserved(int p);
    return (p == 0) || (p >= hole_lo && p < hole_hi) || (p >= hole_hi && p < kern_end);
  endfunction

  function automatic void push_free(logic [PAGE_W-1:0] p);
    link_mem[p] = list_head;
    list_head   = {1'b0, p};
  endfunction

  function automatic void drop_held(logic [PAGE_W-1:0] p);
    int i;
    for (i = held_pages.size() - 1; i >= 0; i--)
      if (held_pages[i] == p) held_pages.delete(i);
  endfunction

  function automatic reply_t apply_page_op(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] p);
    reply_t r;
    int n;
    int i;
    r = '{granted: '0, status: ST_OK, freed: 1'b0, count: '0};
    n = live_pages();
    case (kind)
      KIND_INIT: begin
        list_head = NO_PAGE;
        held_pages.delete();
        for (i = 0; i < n; i++) begin
          if (is_reserved(i)) begin
            count_mem[i] = 16'd1;
          end else begin
            count_mem[i] = '0;
            push_free(PAGE_W'(i));
          end
        end
      end
      KIND_ALLOC: begin
        if (list_head >= NO_PAGE) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted = list_head[PAGE_W-1:0];
          r.count   = count_mem[r.granted];
          list_head = link_mem[r.granted];
          held_pages.push_back(r.granted);
          if (held_pages.size() > 32) void'(held_pages.pop_front());
        end
      end
      KIND_INCREF, KIND_DECREF, KIND_FREE: begin
        if (p >= n) begin
          r.status = ST_RANGE;
        end else if (kind == KIND_INCREF) begin
          if (count_mem[p] != COUNT_TOP) count_mem[p] = count_mem[p] + 1'b1;
          r.count = count_mem[p];
        end else if (kind == KIND_DECREF) begin
          if (count_mem[p] == '0) begin
            r.status = ST_COUNT;
          end else begin
            count_mem[p] = count_mem[p] - 1'b1;
            if (count_mem[p] == '0) begin
              push_free(p);
              r.freed = 1'b1;
            end
            r.count = count_mem[p];
          end
        end else if (count_mem[p] != '0) begin
          r.status = ST_COUNT;
          r.count  = count_mem[p];
        end else begin
          push_free(p);
          r.freed = 1'b1;
        end
        if (r.freed) drop_held(p);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] %s mismatch: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // stimulus queue builders
  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] page);
    stim_q.push_back('{is_cfg: 1'b0, idx: REG_PAGE_COUNT, data: '0, kind: kind, page: page,
                       from_held: 1'b0});
  endtask

  task automatic add_held(input logic [KIND_W-1:0] kind);
    stim_q.push_back('{is_cfg: 1'b0, idx: REG_PAGE_COUNT, data: '0, kind: kind, page: '0,
                       from_held: 1'b1});
  endtask

  task automatic add_cfg(input reg_idx_e idx, input int value);
    stim_q.push_back('{is_cfg: 1'b1, idx: idx, data: REG_W'(value), kind: KIND_INIT,
                       page: '0, from_held: 1'b0});
  endtask

  // write all four registers, then rebuild the list
  task automatic add_setting(input int n, input int lo, input int hi, input int ke);
    add_cfg(REG_PAGE_COUNT, n);
    add_cfg(REG_IO_HOLE_FIRST, lo);
    add_cfg(REG_IO_HOLE_END, hi);
    add_cfg(REG_KERNEL_END, ke);
    add_op(KIND_INIT, '0);
  endtask

  task automatic add_random_op(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) add_op(KIND_ALLOC, PAGE_W'($urandom));
    else if (r < 52) add_held(KIND_INCREF);
    else if (r < 74) add_held(KIND_DECREF);
    else if (r < 84) add_held(KIND_FREE);
    else if (r < 94)
      add_op(KIND_W'($urandom_range(KIND_INCREF, KIND_FREE)),
             $urandom_range(0, 1) ? PAGE_W'($urandom_range(0, n + 3))
                                  : PAGE_W'($urandom_range(0, PAGES - 1)));
    else if (r < 98)
      add_op(KIND_W'($urandom_range(KIND_NONE_LO, KIND_NONE_HI)), PAGE_W'($urandom));
    else add_op(KIND_INIT, PAGE_W'($urandom));
  endtask

  // driver: bursts of beats with random gaps, register writes only when idle
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic nxt_valid;
    logic nxt_we;
    logic accepted;
    stim_t s;
    reply_t r;
    nxt_valid = req_valid;
    nxt_we    = 1'b0;
    accepted  = 1'b0;
    if (rst_n) begin
      if (req_valid && req.ready) begin
        r = apply_page_op(req_kind, req_page);
        pending_replies.push_back(r);
        sent_cnt <= sent_cnt + 1;
        nxt_valid = 1'b0;
        accepted  = 1'b1;
      end
      if (!nxt_valid && stim_q.size() != 0) begin
        s = stim_q[0];
        if (s.is_cfg) begin
          if (!accepted && !req_valid && sent_cnt == done_cnt) begin
            nxt_we = 1'b1;
            cfg_idx <= s.idx;
            cfg_data <= s.data;
            case (s.idx)
              REG_PAGE_COUNT:    pages_cfg = s.data;
              REG_IO_HOLE_FIRST: hole_lo = s.data;
              REG_IO_HOLE_END:   hole_hi = s.data;
              default:           kern_end = s.data;
            endcase
            void'(stim_q.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          if (s.from_held)
            s.page = (held_pages.size() != 0)
                     ? held_pages[$urandom_range(0, held_pages.size() - 1)]
                     : PAGE_W'($urandom_range(0, live_pages() - 1));
          req_kind <= s.kind;
          req_page <= s.page;
          nxt_valid = 1'b1;
          void'(stim_q.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    req_valid <= nxt_valid;
    cfg_we <= nxt_we;
  end

  // monitor: check each reply beat, stall on its own pattern
  int run_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int seen = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    reply_t want;
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (rsp.valid && rsp_ready) begin
        seen++;
        done_cnt <= done_cnt + 1;
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected reply, granted_page", rsp.granted_page, 0);
        end else begin
          want = pending_replies.pop_front();
          if (rsp.granted_page !== want.granted)
            report_mismatch("granted_page", rsp.granted_page, want.granted);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.page_freed !== want.freed)
            report_mismatch("page_freed", rsp.page_freed, want.freed);
          if (rsp.count_after !== want.count)
            report_mismatch("count_after", rsp.count_after, want.count);
        end
      end
      if (!held_once && seen >= 150) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        nxt_ready = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 12);
          stall_left = $urandom_range(1, 5);
        end
      end
    end
    rsp_ready <= nxt_ready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    int n;
    int lo;
    int hi;
    int ke;

    // reset values: 16384 pages with page 0 and 160-255 reserved, highest page first
    add_op(KIND_INIT, '0);
    add_op(KIND_ALLOC, 14'h3FFF);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_INCREF, 14'd16382);
    add_op(KIND_INCREF, 14'd0);
    add_op(KIND_DECREF, 14'd16382);
    add_op(KIND_DECREF, 14'd16382);
    add_op(KIND_FREE, 14'd16383);
    add_op(KIND_FREE, 14'd0);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_FREE, 14'd16383);
    add_op(KIND_FREE, 14'd16383);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_DECREF, 14'd200);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_NONE_LO, 14'h3FFF);
    add_op(KIND_NONE_MID, 14'h2AAA);
    add_op(KIND_NONE_HI, 14'h1555);

    // single page, nothing to hand out
    add_setting(1, 0, 0, 0);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_INCREF, 14'd1);
    add_op(KIND_FREE, 14'h3FFF);
    add_op(KIND_DECREF, 14'd0);
    add_op(KIND_ALLOC, '0);

    // register maxima: count clamped, reserved ranges empty
    add_setting(32767, 32767, 32767, 32767);
    add_op(KIND_ALLOC, '0);
    add_op(KIND_DECREF, 14'd16383);

    // raise one reserved count several times
    add_setting(16, 4, 8, 12);
    for (k = 0; k < INCREF_OPS; k++) add_op(KIND_INCREF, 14'd0);
    add_op(KIND_DECREF, 14'd0);

    for (ph = 0; ph < 6; ph++) begin
      n  = (ph == 5) ? $urandom_range(200, 600) : $urandom_range(2, 48);
      lo = $urandom_range(0, n + 4);
      hi = $urandom_range(0, n + 4);
      ke = $urandom_range(0, n + 8);
      add_setting(n, lo, hi, ke);
      for (k = 0; k < 85; k++) add_random_op(n);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || req_valid || pending_replies.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
